// ===== sv/sacl_pkg.sv =====
// Shared constants and types for the set-associative LRU cache lookup.
// Used by sacl_front, sacl_back and the top level set_assoc_cache_lru_lookup.
package sacl_pkg;

    localparam int DEF_WAYS     = 4;
    localparam int DEF_MAX_SETS = 64;

    localparam int ADDR_W    = 32;
    localparam int TAG_W     = 32;
    localparam int STAMP_W   = 32;
    localparam int CNT_W     = 32;
    localparam int WAY_OUT_W = 2;
    localparam int OFFS_W    = 5;
    localparam int IDXB_W    = 3;

    localparam int S_DATA_W = 32;
    localparam int M_DATA_W = 72;   // 1 + 2 + 32 + 32 = 67, padded to bytes

    localparam int CFG_ADDR_W = 3;
    localparam int CFG_DATA_W = 32;

    localparam logic [OFFS_W-1:0] OFFSET_BITS_RST = OFFS_W'(4);
    localparam logic [IDXB_W-1:0] INDEX_BITS_RST  = IDXB_W'(6);

    // Register select taken from paddr[2]
    localparam logic REG_OFFSET_BITS = 1'b0;
    localparam logic REG_INDEX_BITS  = 1'b1;

    typedef struct packed {
        logic               valid;
        logic [TAG_W-1:0]   tag;
        logic [STAMP_W-1:0] stamp;
    } sacl_entry_t;

    typedef enum logic [2:0] {
        ST_CLEAR = 3'b001,
        ST_IDLE  = 3'b010,
        ST_LOOK  = 3'b100
    } sacl_state_t;

endpackage

// ===== sv/sacl_front.sv =====
// Front part: splits each address into set and tag and holds it in a two-entry queue.
// Depends on sacl_pkg.
module sacl_front
    import sacl_pkg::*;
#(
    parameter int MAX_SETS = DEF_MAX_SETS,
    localparam int SET_W   = (MAX_SETS > 1) ? $clog2(MAX_SETS) : 1,
    localparam int IDX_CAP = $clog2(MAX_SETS + 1) - 1
) (
    input  logic                aclk,
    input  logic                aresetn,
    input  logic                s_tvalid,
    output logic                s_tready,
    input  logic [S_DATA_W-1:0] s_tdata,     // [31:0] address
    input  logic [OFFS_W-1:0]   cfg_offset,
    input  logic [IDXB_W-1:0]   cfg_index,
    input  logic                hold,
    output logic                q_valid,
    input  logic                q_pop,
    output logic [SET_W-1:0]    q_set,
    output logic [TAG_W-1:0]    q_tag
);

    logic [IDXB_W-1:0] ib;
    logic [ADDR_W-1:0] block;
    logic [ADDR_W-1:0] set_full;
    logic [SET_W-1:0]  set_d;
    logic [TAG_W-1:0]  tag_d;
    logic              push;

    logic [SET_W-1:0] set_q_reg [2];
    logic [TAG_W-1:0] tag_q_reg [2];
    logic             wr_ptr_reg, wr_ptr_next;
    logic             rd_ptr_reg, rd_ptr_next;
    logic [1:0]       cnt_reg, cnt_next;

    always_comb begin
        ib       = (int'(cfg_index) > IDX_CAP) ? IDXB_W'(IDX_CAP) : cfg_index;
        block    = s_tdata >> cfg_offset;
        set_full = block & ((ADDR_W'(1) << ib) - ADDR_W'(1));
        set_d    = set_full[SET_W-1:0];
        tag_d    = TAG_W'(block >> ib);
    end

    assign s_tready = (cnt_reg != 2'd2) && !hold;
    assign push     = s_tvalid && s_tready;
    assign q_valid  = (cnt_reg != 2'd0);
    assign q_set    = set_q_reg[rd_ptr_reg];
    assign q_tag    = tag_q_reg[rd_ptr_reg];

    always_comb begin
        wr_ptr_next = wr_ptr_reg ^ push;
        rd_ptr_next = rd_ptr_reg ^ (q_pop && q_valid);
        cnt_next    = cnt_reg + 2'(push) - 2'(q_pop && q_valid);
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            wr_ptr_reg <= 1'b0;
            rd_ptr_reg <= 1'b0;
            cnt_reg    <= 2'd0;
        end else begin
            wr_ptr_reg <= wr_ptr_next;
            rd_ptr_reg <= rd_ptr_next;
            cnt_reg    <= cnt_next;
        end
    end

    always_ff @(posedge aclk) begin
        if (push) begin
            set_q_reg[wr_ptr_reg] <= set_d;
            tag_q_reg[wr_ptr_reg] <= tag_d;
        end
    end

endmodule

// ===== sv/sacl_back.sv =====
// Back part: per-way set memories, tag compare, LRU victim pick, counters, result register.
// Depends on sacl_pkg.
module sacl_back
    import sacl_pkg::*;
#(
    parameter int WAYS     = DEF_WAYS,
    parameter int MAX_SETS = DEF_MAX_SETS,
    localparam int SET_W   = (MAX_SETS > 1) ? $clog2(MAX_SETS) : 1,
    localparam int WAY_W   = (WAYS > 1) ? $clog2(WAYS) : 1,
    localparam int WP      = 1 << WAY_W
) (
    input  logic                aclk,
    input  logic                aresetn,
    input  logic                q_valid,
    output logic                q_pop,
    input  logic [SET_W-1:0]    q_set,
    input  logic [TAG_W-1:0]    q_tag,
    output logic                clearing,
    output logic                m_tvalid,
    input  logic                m_tready,
    output logic [M_DATA_W-1:0] m_tdata   // hit, way[1:0], hit_count[31:0], miss_count[31:0]
);

    sacl_state_t state_reg, state_next;
    logic [SET_W-1:0]   clr_reg, clr_next;
    logic [STAMP_W-1:0] acc_reg, acc_next;
    logic [CNT_W-1:0]   hits_reg, hits_next;
    logic [CNT_W-1:0]   miss_reg, miss_next;
    logic [SET_W-1:0]   set_reg;
    logic [TAG_W-1:0]   tag_reg;

    logic                 out_valid_reg, out_valid_next;
    logic                 out_hit_reg;
    logic [WAY_OUT_W-1:0] out_way_reg;
    logic [CNT_W-1:0]     out_hits_reg;
    logic [CNT_W-1:0]     out_miss_reg;

    sacl_entry_t      rd_q [WAYS];
    logic [WAYS-1:0]  we;
    logic [SET_W-1:0] wr_addr;
    sacl_entry_t      wr_data;
    logic             look_go;

    logic               hit_any;
    logic [WAY_W-1:0]   hit_way;
    logic [WAY_W-1:0]   pick;
    logic [STAMP_W-1:0] node_stamp [2*WP-1];
    logic [WAY_W-1:0]   node_idx   [2*WP-1];

    assign clearing = (state_reg == ST_CLEAR);
    assign q_pop    = (state_reg == ST_IDLE) && q_valid;
    assign look_go  = (state_reg == ST_LOOK) && (!out_valid_reg || m_tready);

    // Way memories: one row per set, written and read in clocked blocks
    for (genvar w = 0; w < WAYS; w++) begin : g_way
        sacl_entry_t mem [MAX_SETS];
        always_ff @(posedge aclk) begin
            if (we[w]) begin
                mem[wr_addr] <= wr_data;
            end
            if (q_pop) begin
                rd_q[w] <= mem[q_set];
            end
        end
    end

    // Hit search: lowest matching valid way wins
    always_comb begin
        hit_any = 1'b0;
        hit_way = '0;
        for (int w = WAYS - 1; w >= 0; w--) begin
            if (rd_q[w].valid && rd_q[w].tag == tag_reg) begin
                hit_any = 1'b1;
                hit_way = WAY_W'(w);
            end
        end
    end

    // Victim search: tree of min compares, left side keeps ties
    always_comb begin
        for (int j = 0; j < WP; j++) begin
            node_stamp[WP-1+j] = (j < WAYS) ? rd_q[j].stamp : '1;
            node_idx[WP-1+j]   = WAY_W'(j);
        end
        for (int i = WP - 2; i >= 0; i--) begin
            if (node_stamp[2*i+2] < node_stamp[2*i+1]) begin
                node_stamp[i] = node_stamp[2*i+2];
                node_idx[i]   = node_idx[2*i+2];
            end else begin
                node_stamp[i] = node_stamp[2*i+1];
                node_idx[i]   = node_idx[2*i+1];
            end
        end
        pick = hit_any ? hit_way : node_idx[0];
    end

    always_comb begin
        acc_next = acc_reg + STAMP_W'(1);
        if (clearing) begin
            wr_addr = clr_reg;
            wr_data = '0;
        end else begin
            wr_addr       = set_reg;
            wr_data.valid = 1'b1;
            wr_data.tag   = tag_reg;
            wr_data.stamp = acc_next;
        end
        for (int w = 0; w < WAYS; w++) begin
            we[w] = clearing || (look_go && pick == WAY_W'(w));
        end
    end

    always_comb begin
        state_next     = state_reg;
        clr_next       = clr_reg;
        hits_next      = hits_reg;
        miss_next      = miss_reg;
        out_valid_next = out_valid_reg && !m_tready;
        case (state_reg)
            ST_CLEAR: begin
                clr_next = clr_reg + SET_W'(1);
                if (clr_reg == SET_W'(MAX_SETS - 1)) begin
                    state_next = ST_IDLE;
                end
            end
            ST_IDLE: begin
                if (q_valid) begin
                    state_next = ST_LOOK;
                end
            end
            ST_LOOK: begin
                if (look_go) begin
                    state_next     = ST_IDLE;
                    out_valid_next = 1'b1;
                    if (hit_any) begin
                        hits_next = hits_reg + CNT_W'(!(&hits_reg));
                    end else begin
                        miss_next = miss_reg + CNT_W'(!(&miss_reg));
                    end
                end
            end
            default: state_next = ST_CLEAR;
        endcase
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg     <= ST_CLEAR;
            clr_reg       <= '0;
            acc_reg       <= '0;
            hits_reg      <= '0;
            miss_reg      <= '0;
            out_valid_reg <= 1'b0;
        end else begin
            state_reg     <= state_next;
            clr_reg       <= clr_next;
            hits_reg      <= hits_next;
            miss_reg      <= miss_next;
            out_valid_reg <= out_valid_next;
            if (look_go) begin
                acc_reg <= acc_next;
            end
        end
    end

    always_ff @(posedge aclk) begin
        if (q_pop) begin
            set_reg <= q_set;
            tag_reg <= q_tag;
        end
        if (look_go) begin
            out_hit_reg  <= hit_any;
            out_way_reg  <= WAY_OUT_W'(pick);
            out_hits_reg <= hits_next;
            out_miss_reg <= miss_next;
        end
    end

    assign m_tvalid = out_valid_reg;
    assign m_tdata  = {5'b0, out_miss_reg, out_hits_reg, out_way_reg, out_hit_reg};

endmodule

// ===== sv/set_assoc_cache_lru_lookup.sv =====
// Top level of the set-associative LRU cache lookup: configuration registers and wiring.
// Depends on sacl_pkg, sacl_front and sacl_back.
//
// Each accepted item is a 32-bit byte address; the block returns one result per item:
// hit flag, the way that hit or was filled, and saturating hit and miss counts. The lookup
// unit reads the set from the per-way memories, then compares all ways, picks the least
// recently used way on a miss and writes back tag and stamp; it takes the next item only
// after that write-back, which waits while the output register holds an untaken result. A
// two-entry queue sits in front of the lookup unit. After reset a clearing pass over all
// MAX_SETS sets wipes the set memories; no item is accepted during it. offset_bits is at
// byte address 0 and index_bits at 4; write them only while idle.
module set_assoc_cache_lru_lookup
    import sacl_pkg::*;
#(
    parameter int WAYS     = DEF_WAYS,
    parameter int MAX_SETS = DEF_MAX_SETS,
    localparam int SET_W   = (MAX_SETS > 1) ? $clog2(MAX_SETS) : 1
) (
    input  logic                  aclk,
    input  logic                  aresetn,
    input  logic                  s_tvalid,
    output logic                  s_tready,
    input  logic [S_DATA_W-1:0]   s_tdata,   // [31:0] address
    output logic                  m_tvalid,
    input  logic                  m_tready,
    output logic [M_DATA_W-1:0]   m_tdata,   // [0] hit, [2:1] way, [34:3] hit_count,
                                             // [66:35] miss_count, [71:67] zero
    input  logic                  psel,
    input  logic                  penable,
    input  logic                  pwrite,
    input  logic [CFG_ADDR_W-1:0] paddr,
    input  logic [CFG_DATA_W-1:0] pwdata,
    output logic [CFG_DATA_W-1:0] prdata,
    output logic                  pready
);

    logic [OFFS_W-1:0] offset_bits_reg;
    logic [IDXB_W-1:0] index_bits_reg;
    logic              cfg_wr;

    logic             q_valid;
    logic             q_pop;
    logic [SET_W-1:0] q_set;
    logic [TAG_W-1:0] q_tag;
    logic             clearing;

    assign pready = 1'b1;
    assign cfg_wr = psel && penable && pwrite && pready;

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            offset_bits_reg <= OFFSET_BITS_RST;
            index_bits_reg  <= INDEX_BITS_RST;
        end else if (cfg_wr) begin
            if (paddr[2] == REG_OFFSET_BITS) begin
                offset_bits_reg <= pwdata[OFFS_W-1:0];
            end else begin
                index_bits_reg <= pwdata[IDXB_W-1:0];
            end
        end
    end

    assign prdata = (paddr[2] == REG_OFFSET_BITS) ? CFG_DATA_W'(offset_bits_reg)
                                                  : CFG_DATA_W'(index_bits_reg);

    sacl_front #(
        .MAX_SETS (MAX_SETS)
    ) u_front (
        .aclk       (aclk),
        .aresetn    (aresetn),
        .s_tvalid   (s_tvalid),
        .s_tready   (s_tready),
        .s_tdata    (s_tdata),
        .cfg_offset (offset_bits_reg),
        .cfg_index  (index_bits_reg),
        .hold       (clearing),
        .q_valid    (q_valid),
        .q_pop      (q_pop),
        .q_set      (q_set),
        .q_tag      (q_tag)
    );

    sacl_back #(
        .WAYS     (WAYS),
        .MAX_SETS (MAX_SETS)
    ) u_back (
        .aclk     (aclk),
        .aresetn  (aresetn),
        .q_valid  (q_valid),
        .q_pop    (q_pop),
        .q_set    (q_set),
        .q_tag    (q_tag),
        .clearing (clearing),
        .m_tvalid (m_tvalid),
        .m_tready (m_tready),
        .m_tdata  (m_tdata)
    );

endmodule

// ===== verif/tb_set_assoc_cache_lru_lookup.sv =====
// Self-checking testbench for set_assoc_cache_lru_lookup: drives address items, predicts
// hit/way/counts with an LRU cache model kept in this file, and checks every result item.
// Depends on sacl_pkg and the RTL of the block only.
module tb_set_assoc_cache_lru_lookup;
    timeunit 1ns;
    timeprecision 1ps;
    import sacl_pkg::*;

    localparam int ENTRIES     = DEF_WAYS * DEF_MAX_SETS;
    localparam int IDX_CAP     = $clog2(DEF_MAX_SETS + 1) - 1;
    localparam int CYCLE_LIMIT = 200000;
    localparam logic [CFG_ADDR_W-1:0] OFFSET_ADDR = {REG_OFFSET_BITS, 2'b00};
    localparam logic [CFG_ADDR_W-1:0] INDEX_ADDR  = {REG_INDEX_BITS, 2'b00};

    typedef struct packed {
        logic [M_DATA_W-68:0]  pad;
        logic [CNT_W-1:0]      miss_count;
        logic [CNT_W-1:0]      hit_count;
        logic [WAY_OUT_W-1:0]  way;
        logic                  hit;
    } lookup_result_t;

    logic                  aclk     = 1'b0;
    logic                  aresetn  = 1'b0;
    logic                  s_tvalid = 1'b0;
    logic                  s_tready;
    logic [S_DATA_W-1:0]   s_tdata  = '0;     // [31:0] address
    logic                  m_tvalid;
    logic                  m_tready = 1'b0;
    logic [M_DATA_W-1:0]   m_tdata;           // [0] hit, [2:1] way, [34:3] hit_count,
                                              // [66:35] miss_count, [71:67] zero
    logic                  psel     = 1'b0;
    logic                  penable  = 1'b0;
    logic                  pwrite   = 1'b0;
    logic [CFG_ADDR_W-1:0] paddr    = '0;
    logic [CFG_DATA_W-1:0] pwdata   = '0;
    logic [CFG_DATA_W-1:0] prdata;
    logic                  pready;

    // Cache model state
    bit [OFFS_W-1:0]  offset_bits_cfg = OFFSET_BITS_RST;
    bit [IDXB_W-1:0]  index_bits_cfg  = INDEX_BITS_RST;
    bit               valid_mem [ENTRIES];
    bit [TAG_W-1:0]   tag_mem   [ENTRIES];
    bit [STAMP_W-1:0] stamp_mem [ENTRIES];
    bit [STAMP_W-1:0] access_stamp;
    bit [CNT_W-1:0]   hits_total;
    bit [CNT_W-1:0]   misses_total;

    lookup_result_t pending_lookups [$];
    int fail_count  = 0;
    int cycle_count = 0;
    int gap_max     = 4;
    int stall_max   = 4;
    int hold_cycles = 0;

    set_assoc_cache_lru_lookup u_top (
        .aclk     (aclk),
        .aresetn  (aresetn),
        .s_tvalid (s_tvalid),
        .s_tready (s_tready),
        .s_tdata  (s_tdata),
        .m_tvalid (m_tvalid),
        .m_tready (m_tready),
        .m_tdata  (m_tdata),
        .psel     (psel),
        .penable  (penable),
        .pwrite   (pwrite),
        .paddr    (paddr),
        .pwdata   (pwdata),
        .prdata   (prdata),
        .pready   (pready)
    );

    always #4 aclk = ~aclk;

    always @(posedge aclk) begin
        cycle_count++;
        if (cycle_count > CYCLE_LIMIT) begin
            $display("Regression FAIL");
            $finish;
        end
    end

    function automatic int used_index_bits();
        return (index_bits_cfg > IDX_CAP) ? IDX_CAP : int'(index_bits_cfg);
    endfunction

    function automatic lookup_result_t predict_lookup(input logic [ADDR_W-1:0] address);
        lookup_result_t res;
        logic [31:0]    block_no;
        logic [31:0]    set_no;
        logic [31:0]    tag_val;
        int             ib;
        int             base;
        int             pick;
        logic           hit;
        ib       = used_index_bits();
        block_no = address >> offset_bits_cfg;
        set_no   = block_no & ((32'd1 << ib) - 32'd1);
        tag_val  = block_no >> ib;
        base     = int'(set_no) * DEF_WAYS;
        access_stamp = access_stamp + 1'b1;
        hit  = 1'b0;
        pick = 0;
        for (int w = 0; w < DEF_WAYS; w++) begin
            if (!hit && valid_mem[base + w] && tag_mem[base + w] == tag_val) begin
                hit  = 1'b1;
                pick = w;
            end
        end
        if (hit) begin
            if (hits_total != '1) hits_total++;
        end else begin
            if (misses_total != '1) misses_total++;
            // oldest stamp loses its way; lowest way wins a tie
            for (int w = 1; w < DEF_WAYS; w++) begin
                if (stamp_mem[base + w] < stamp_mem[base + pick]) pick = w;
            end
            valid_mem[base + pick] = 1'b1;
            tag_mem[base + pick]   = tag_val;
        end
        stamp_mem[base + pick] = access_stamp;
        res            = '0;
        res.hit        = hit;
        res.way        = WAY_OUT_W'(pick);
        res.hit_count  = hits_total;
        res.miss_count = misses_total;
        return res;
    endfunction

    // Mostly a small pool of tags over a few sets, so that hits and evictions are common
    function automatic logic [ADDR_W-1:0] pick_address(input logic [31:0] tag_base);
        logic [63:0] blk;
        logic [31:0] low;
        int          ib;
        if ($urandom_range(0, 9) < 2) return $urandom;
        ib  = used_index_bits();
        blk = (64'(tag_base + $urandom_range(0, 5)) << ib)
            | 64'($urandom_range(0, 3) & ((32'd1 << ib) - 32'd1));
        low = $urandom & ((32'd1 << offset_bits_cfg) - 32'd1);
        return 32'((blk << offset_bits_cfg) | 64'(low));
    endfunction

    // Call at a falling edge; returns at the falling edge after the item is taken
    task automatic send_address(input logic [ADDR_W-1:0] address);
        int gap;
        gap = $urandom_range(0, gap_max);
        if (gap > 0) begin
            s_tvalid <= 1'b0;
            repeat (gap) @(negedge aclk);
        end
        s_tvalid <= 1'b1;
        s_tdata  <= address;
        do @(posedge aclk); while (!s_tready);
        pending_lookups.push_back(predict_lookup(address));
        @(negedge aclk);
    endtask

    task automatic drain_results();
        s_tvalid <= 1'b0;
        while (pending_lookups.size() != 0) @(negedge aclk);
        repeat (4) @(negedge aclk);
    endtask

    task automatic apb_transfer(input logic write, input logic [CFG_ADDR_W-1:0] addr,
                                input logic [CFG_DATA_W-1:0] wdata,
                                output logic [CFG_DATA_W-1:0] rdata);
        psel    <= 1'b1;
        penable <= 1'b0;
        pwrite  <= write;
        paddr   <= addr;
        pwdata  <= wdata;
        @(negedge aclk);
        penable <= 1'b1;
        do @(posedge aclk); while (!pready);
        rdata = prdata;
        if (write) begin
            if (addr == OFFSET_ADDR) offset_bits_cfg = wdata[OFFS_W-1:0];
            else index_bits_cfg = wdata[IDXB_W-1:0];
        end
        @(negedge aclk);
        psel    <= 1'b0;
        penable <= 1'b0;
        @(negedge aclk);
    endtask

    task automatic check_registers();
        logic [CFG_DATA_W-1:0] rd;
        apb_transfer(1'b0, OFFSET_ADDR, '0, rd);
        if (rd[OFFS_W-1:0] !== offset_bits_cfg) begin
            $error("offset_bits: expected %0d, got %0d", offset_bits_cfg, rd[OFFS_W-1:0]);
            fail_count++;
        end
        apb_transfer(1'b0, INDEX_ADDR, '0, rd);
        if (rd[IDXB_W-1:0] !== index_bits_cfg) begin
            $error("index_bits: expected %0d, got %0d", index_bits_cfg, rd[IDXB_W-1:0]);
            fail_count++;
        end
    endtask

    // Stored lines stay; they are read under the new geometry
    task automatic set_geometry(input logic [OFFS_W-1:0] off, input logic [IDXB_W-1:0] idx);
        logic [CFG_DATA_W-1:0] rd;
        drain_results();
        apb_transfer(1'b1, OFFSET_ADDR, {27'($urandom), off}, rd);
        apb_transfer(1'b1, INDEX_ADDR, {29'($urandom), idx}, rd);
        check_registers();
    endtask

    always @(posedge aclk) begin
        lookup_result_t got;
        lookup_result_t want;
        if (aresetn && m_tvalid && m_tready) begin
            got = lookup_result_t'(m_tdata);
            if (pending_lookups.size() == 0) begin
                $error("result item with no lookup pending: %h", m_tdata);
                fail_count++;
            end else begin
                want = pending_lookups.pop_front();
                if (got.hit !== want.hit) begin
                    $error("hit: expected %0d, got %0d", want.hit, got.hit);
                    fail_count++;
                end
                if (got.way !== want.way) begin
                    $error("way: expected %0d, got %0d", want.way, got.way);
                    fail_count++;
                end
                if (got.hit_count !== want.hit_count) begin
                    $error("hit_count: expected %0d, got %0d", want.hit_count, got.hit_count);
                    fail_count++;
                end
                if (got.miss_count !== want.miss_count) begin
                    $error("miss_count: expected %0d, got %0d",
                           want.miss_count, got.miss_count);
                    fail_count++;
                end
                if (got.pad !== want.pad) begin
                    $error("pad: expected %0d, got %0d", want.pad, got.pad);
                    fail_count++;
                end
            end
        end
    end

    // Result side: random stall per item, or one long hold when requested
    initial begin
        int stall;
        wait (aresetn);
        @(negedge aclk);
        forever begin
            if (hold_cycles > 0) begin
                stall = hold_cycles;
                hold_cycles = 0;
            end else begin
                stall = $urandom_range(0, stall_max);
            end
            if (stall > 0) begin
                m_tready <= 1'b0;
                repeat (stall) @(negedge aclk);
            end
            m_tready <= 1'b1;
            do @(posedge aclk); while (!m_tvalid);
            @(negedge aclk);
        end
    end

    task automatic test_reset_values();
        check_registers();
    endtask

    task automatic test_hit_and_lru_order();
        logic [ADDR_W-1:0] seq [12] = '{
            32'h0000_0000, 32'h0000_000F, 32'hFFFF_FFFF, 32'hFFFF_FFF0,
            32'h0000_0400, 32'h0000_0800, 32'h0000_0C00, 32'h0000_0004,
            32'h0000_1000, 32'h0000_0400, 32'h0000_0C05, 32'h0000_0800
        };
        foreach (seq[i]) send_address(seq[i]);
    endtask

    task automatic test_geometry_extremes();
        logic [ADDR_W-1:0] one_set [6] = '{
            32'h0000_0000, 32'h0000_0001, 32'h0000_0002, 32'h0000_0003,
            32'h0000_0004, 32'h0000_0000
        };
        logic [ADDR_W-1:0] wide_block [4] = '{
            32'h0000_0000, 32'h7FFF_FFFF, 32'h8000_0000, 32'hFFFF_FFFF
        };
        set_geometry(5'd0, 3'd0);
        foreach (one_set[i]) send_address(one_set[i]);
        // index_bits above the cap acts as the cap
        set_geometry(5'd31, 3'd7);
        foreach (wide_block[i]) send_address(wide_block[i]);
    endtask

    task automatic test_backpressure();
        set_geometry(5'd4, 3'd6);
        gap_max     = 0;
        hold_cycles = 150;
        repeat (24) send_address(pick_address(32'd0));
        gap_max   = 4;
        stall_max = 4;
    endtask

    task automatic test_random_traffic();
        logic [OFFS_W-1:0] offs [6] = '{5'd4, 5'd0, 5'd31, 5'd16, 5'd9, 5'd2};
        logic [IDXB_W-1:0] idxs [6] = '{3'd6, 3'd0, 3'd7, 3'd3, 3'd2, 3'd5};
        logic [31:0]       tag_base;
        for (int p = 0; p < 6; p++) begin
            set_geometry(offs[p], idxs[p]);
            gap_max   = (p % 3 == 0) ? 4 : 0;
            stall_max = (p % 3 == 1) ? 0 : 4;
            tag_base  = $urandom_range(0, 1) ? $urandom : 32'd0;
            repeat (80) send_address(pick_address(tag_base));
        end
    endtask

    initial begin
        repeat (12) @(negedge aclk);
        aresetn <= 1'b1;
        test_reset_values();
        test_hit_and_lru_order();
        test_geometry_extremes();
        test_backpressure();
        test_random_traffic();
        drain_results();
        repeat (16) @(negedge aclk);
        if (fail_count == 0) begin
            $display("Regression PASS");
        end else begin
            $display("Regression FAIL");
        end
        $finish;
    end

endmodule
